@@ sv/ptl_pkg.sv @@
`default_nettype none

package ptl_pkg;

  // index width of vertices and results
  localparam int unsigned IDX_W = 16;

  // entries in the primitive queue between assembler and serializer
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // topology register codes, six and seven have no meaning
  typedef enum logic [2:0] {
    TOPO_POINTS     = 3'd0,
    TOPO_LINES      = 3'd1,
    TOPO_LINE_STRIP = 3'd2,
    TOPO_TRIS       = 3'd3,
    TOPO_TRI_STRIP  = 3'd4,
    TOPO_TRI_FAN    = 3'd5
  } topo_e;

  localparam topo_e TOPO_RESET = TOPO_TRI_STRIP;

  // one assembled primitive, cnt holds the number of indices (1 to 3)
  typedef struct packed {
    logic [2:0][IDX_W-1:0] idx;
    logic [1:0]            cnt;
  } prim_t;

endpackage

`default_nettype wire

@@ sv/primitive_topology_to_list.sv @@
// Primitive assembler: turns a stream of vertex indices in point list,
// line list, line strip, triangle list, triangle strip or triangle fan
// form into list-form indices, one index per output transaction.
// Input channel: in_valid_i / in_stall_o with vertex_index_i and
// last_vertex_i; last_vertex_i ends the current strip and drops any
// partial primitive. Output channel: out_valid_o / out_stall_i with
// out_index_o and primitive_end_o, set on the last index of a primitive.
// Configuration: cfg_valid_i / cfg_ready_o writes cfg_topology_i; the
// write also restarts assembly. Write it only while the block is idle.
// The first index of a primitive passes through the primitive queue and
// the output register. The output port moves one index per cycle while
// out_stall_i is low, and a vertex is accepted every cycle while the
// two-entry primitive queue has room.
// Reset: topology is triangle strip, queue and output are empty.
// A stalled receiver holds the output register; the queue fills and
// then in_stall_o rises until the serializer drains an entry.
`default_nettype none

module primitive_topology_to_list import ptl_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [2:0]       cfg_topology_i,
  // vertex input
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [IDX_W-1:0] vertex_index_i,
  input  wire logic             last_vertex_i,
  // index output
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [IDX_W-1:0]      out_index_o,
  output logic                  primitive_end_o
);

  logic  push, full, q_valid, pop;
  prim_t prim, head;

  assign cfg_ready_o = 1'b1;

  ptl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_topology_i (cfg_topology_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vertex_index_i (vertex_index_i),
    .last_vertex_i  (last_vertex_i),
    .push_o         (push),
    .prim_o         (prim),
    .full_i         (full)
  );

  ptl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .prim_i  (prim),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  ptl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_index_o     (out_index_o),
    .primitive_end_o (primitive_end_o)
  );

endmodule

`default_nettype wire

@@ sv/ptl_front.sv @@
`default_nettype none

module ptl_front import ptl_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // topology write
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_topology_i,
  // vertex transaction
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [IDX_W-1:0] vertex_index_i,
  input  wire logic             last_vertex_i,
  // primitive queue write side
  output logic                  push_o,
  output prim_t                 prim_o,
  input  wire logic             full_i
);

  topo_e            topology_q;
  logic [IDX_W-1:0] older_q, older_d;
  logic [IDX_W-1:0] newer_q, newer_d;
  logic [IDX_W-1:0] anchor_q, anchor_d;
  logic [1:0]       seen_q, seen_d;
  logic             odd_q, odd_d;
  logic             accept;
  logic             emit;
  prim_t            prim;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // assembly step for one vertex
  always_comb begin
    older_d  = older_q;
    newer_d  = newer_q;
    anchor_d = anchor_q;
    seen_d   = seen_q;
    odd_d    = odd_q;
    emit     = 1'b0;
    prim     = '0;
    case (topology_q)
      TOPO_POINTS: begin
        prim.idx[0] = vertex_index_i;
        prim.cnt    = 2'd1;
        emit        = 1'b1;
      end
      TOPO_LINES: begin
        if (seen_q == 2'd0) begin
          older_d = vertex_index_i;
          seen_d  = 2'd1;
        end else begin
          prim.idx[0] = older_q;
          prim.idx[1] = vertex_index_i;
          prim.cnt    = 2'd2;
          emit        = 1'b1;
          seen_d      = 2'd0;
        end
      end
      TOPO_LINE_STRIP: begin
        if (seen_q != 2'd0) begin
          prim.idx[0] = newer_q;
          prim.idx[1] = vertex_index_i;
          prim.cnt    = 2'd2;
          emit        = 1'b1;
        end
        newer_d = vertex_index_i;
        seen_d  = 2'd1;
      end
      TOPO_TRIS: begin
        if (seen_q == 2'd0) begin
          older_d = vertex_index_i;
          seen_d  = 2'd1;
        end else if (seen_q == 2'd1) begin
          newer_d = vertex_index_i;
          seen_d  = 2'd2;
        end else begin
          prim.idx[0] = older_q;
          prim.idx[1] = newer_q;
          prim.idx[2] = vertex_index_i;
          prim.cnt    = 2'd3;
          emit        = 1'b1;
          seen_d      = 2'd0;
        end
      end
      TOPO_TRI_STRIP: begin
        if (seen_q == 2'd0) begin
          older_d = vertex_index_i;
          seen_d  = 2'd1;
        end else if (seen_q == 2'd1) begin
          newer_d = vertex_index_i;
          seen_d  = 2'd2;
        end else begin
          // odd triangles swap the last two to keep the winding
          prim.idx[0] = older_q;
          prim.idx[1] = odd_q ? vertex_index_i : newer_q;
          prim.idx[2] = odd_q ? newer_q : vertex_index_i;
          prim.cnt    = 2'd3;
          emit        = 1'b1;
          odd_d       = ~odd_q;
          older_d     = newer_q;
          newer_d     = vertex_index_i;
        end
      end
      TOPO_TRI_FAN: begin
        if (seen_q == 2'd0) begin
          anchor_d = vertex_index_i;
          seen_d   = 2'd1;
        end else if (seen_q == 2'd1) begin
          newer_d = vertex_index_i;
          seen_d  = 2'd2;
        end else begin
          prim.idx[0] = anchor_q;
          prim.idx[1] = newer_q;
          prim.idx[2] = vertex_index_i;
          prim.cnt    = 2'd3;
          emit        = 1'b1;
          newer_d     = vertex_index_i;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // end of strip drops any partial primitive
    if (last_vertex_i) begin
      seen_d = 2'd0;
      odd_d  = 1'b0;
    end
  end

  assign push_o = accept && emit;
  assign prim_o = prim;

  // assembler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topology_q <= TOPO_RESET;
      older_q    <= '0;
      newer_q    <= '0;
      anchor_q   <= '0;
      seen_q     <= 2'd0;
      odd_q      <= 1'b0;
    end else if (cfg_we_i) begin
      topology_q <= topo_e'(cfg_topology_i);
      seen_q     <= 2'd0;
      odd_q      <= 1'b0;
    end else if (accept) begin
      older_q  <= older_d;
      newer_q  <= newer_d;
      anchor_q <= anchor_d;
      seen_q   <= seen_d;
      odd_q    <= odd_d;
    end
  end

  // checks
  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3)
    else $error("seen count out of range");

  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (prim_o.cnt != 2'd0))
    else $error("empty primitive pushed");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_vertex_i && !cfg_we_i) |=> (seen_q == 2'd0 && !odd_q))
    else $error("end of strip did not clear assembly state");

endmodule

`default_nettype wire

@@ sv/ptl_queue.sv @@
`default_nettype none

module ptl_queue import ptl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire prim_t prim_i,
  output logic       full_o,
  output logic       valid_o,
  output prim_t      head_o,
  input  wire logic  pop_i
);

  prim_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= prim_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count missed a push");

endmodule

`default_nettype wire

@@ sv/ptl_back.sv @@
`default_nettype none

module ptl_back import ptl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // primitive queue read side
  input  wire logic        valid_i,
  input  wire prim_t       head_i,
  output logic             pop_o,
  // index transaction
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [IDX_W-1:0] out_index_o,
  output logic             primitive_end_o
);

  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_index_q, out_index_d;
  logic             out_end_q, out_end_d;
  logic [1:0]       pos_q, pos_d;
  logic             can_load;
  logic             at_end;

  assign can_load = !out_valid_q || !out_stall_i;
  assign at_end   = (pos_q == head_i.cnt - 2'd1);

  // walk the head primitive one index per cycle while the output is not stalled
  always_comb begin
    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    out_end_d   = out_end_q;
    pos_d       = pos_q;
    pop_o       = 1'b0;
    if (can_load) begin
      out_valid_d = valid_i;
      if (valid_i) begin
        out_index_d = head_i.idx[pos_q];
        out_end_d   = at_end;
        if (at_end) begin
          pos_d = 2'd0;
          pop_o = 1'b1;
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_index_q <= out_index_d;
    out_end_q   <= out_end_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_index_o     = out_index_q;
  assign primitive_end_o = out_end_q;

  // checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (pos_q < head_i.cnt))
    else $error("index position past primitive size");

  a_pop_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_end_q))
    else $error("pop without primitive end on output");

  a_pos_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (pos_q == 2'd0))
    else $error("position not rewound after primitive");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
  import ptl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 25;
  localparam longint unsigned TIMEOUT_NS = 2000000;

  // topology codes the package leaves unnamed
  localparam logic [2:0] TOPO_UNDEF6 = 3'd6;
  localparam logic [2:0] TOPO_UNDEF7 = 3'd7;

  // one row of the directed table: a topology write or a vertex
  typedef struct packed {
    logic                  is_cfg;
    logic [2:0]            topo;
    logic [IDX_W-1:0]      vtx;
    logic                  last;
    logic                  typed;
    logic [1:0]            n;
    logic [2:0][IDX_W-1:0] idx;
  } vector_row_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  logic [2:0]       cfg_topology_i = TOPO_RESET;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic [IDX_W-1:0] vertex_index_i = '0;
  logic             last_vertex_i  = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [IDX_W-1:0] out_index_o;
  logic             primitive_end_o;

  // expected indices in list order, {primitive_end, out_index}
  logic [IDX_W:0] pending_indices[$];
  vector_row_t    directed_rows[$];

  // assembler state as the block should hold it
  logic [2:0]       topo_q;
  logic [IDX_W-1:0] older_q;
  logic [IDX_W-1:0] newer_q;
  logic [IDX_W-1:0] anchor_q;
  int unsigned      seen_q;
  logic             odd_q;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned errors;
  int unsigned vertices_sent;
  int unsigned indices_checked;
  int unsigned topo_writes;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  primitive_topology_to_list i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_topology_i  (cfg_topology_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .vertex_index_i  (vertex_index_i),
    .last_vertex_i   (last_vertex_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_index_o     (out_index_o),
    .primitive_end_o (primitive_end_o)
  );

  // list-form indices produced by one vertex, first index in prim[0]
  task automatic assemble_vertex(input logic [IDX_W-1:0] v, input logic last,
                                 output int n, output logic [2:0][IDX_W-1:0] prim);
    n = 0;
    prim = '0;
    case (topo_q)
      TOPO_POINTS: begin
        prim[0] = v;
        n = 1;
      end
      TOPO_LINES: begin
        if (seen_q == 0) begin
          older_q = v;
          seen_q = 1;
        end else begin
          prim[0] = older_q;
          prim[1] = v;
          n = 2;
          seen_q = 0;
        end
      end
      TOPO_LINE_STRIP: begin
        if (seen_q != 0) begin
          prim[0] = newer_q;
          prim[1] = v;
          n = 2;
        end
        newer_q = v;
        seen_q = 1;
      end
      TOPO_TRIS: begin
        if (seen_q == 0) begin
          older_q = v;
          seen_q = 1;
        end else if (seen_q == 1) begin
          newer_q = v;
          seen_q = 2;
        end else begin
          prim = {v, newer_q, older_q};
          n = 3;
          seen_q = 0;
        end
      end
      TOPO_TRI_STRIP: begin
        if (seen_q == 0) begin
          older_q = v;
          seen_q = 1;
        end else if (seen_q == 1) begin
          newer_q = v;
          seen_q = 2;
        end else begin
          // odd triangles swap the last two to keep the winding
          if (odd_q) prim = {newer_q, v, older_q};
          else prim = {v, newer_q, older_q};
          n = 3;
          odd_q = ~odd_q;
          older_q = newer_q;
          newer_q = v;
        end
      end
      TOPO_TRI_FAN: begin
        if (seen_q == 0) begin
          anchor_q = v;
          seen_q = 1;
        end else if (seen_q == 1) begin
          newer_q = v;
          seen_q = 2;
        end else begin
          prim = {v, newer_q, anchor_q};
          n = 3;
          newer_q = v;
        end
      end
      default: ;
    endcase
    if (last) begin
      seen_q = 0;
      odd_q = 1'b0;
    end
  endtask

  task automatic add_topo(input logic [2:0] t);
    vector_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.topo = t;
    directed_rows = {directed_rows, row};
  endtask

  // typed rows carry their expected indices, the others use the predictor
  task automatic add_vertex(input logic [IDX_W-1:0] v, input logic last,
                            input logic typed, input logic [1:0] n,
                            input logic [IDX_W-1:0] i0, input logic [IDX_W-1:0] i1,
                            input logic [IDX_W-1:0] i2);
    vector_row_t row;
    row = '0;
    row.vtx = v;
    row.last = last;
    row.typed = typed;
    row.n = n;
    row.idx = {i2, i1, i0};
    directed_rows = {directed_rows, row};
  endtask

  // topology write, only once every index has left and the block has settled
  task automatic write_topology(input logic [2:0] t);
    in_valid_i <= 1'b0;
    while (pending_indices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_topology_i <= t;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    topo_q = t;
    seen_q = 0;
    odd_q = 1'b0;
    topo_writes++;
  endtask

  // one vertex transaction; returns at the edge that accepts it
  task automatic send_vertex(input logic [IDX_W-1:0] v, input logic last,
                             input logic typed, input logic [1:0] tn,
                             input logic [2:0][IDX_W-1:0] tidx);
    int n;
    logic [2:0][IDX_W-1:0] prim;
    logic [IDX_W:0] item;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_index_i <= v;
    last_vertex_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    vertices_sent++;
    assemble_vertex(v, last, n, prim);
    if (typed) begin
      n = tn;
      prim = tidx;
    end
    for (int k = 0; k < n; k++) begin
      item = {k == n - 1, prim[k]};
      pending_indices = {pending_indices, item};
    end
  endtask

  // mix of sequential runs, extremes and fully random indices
  function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] base, input int k);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '1;
    if (r < 16) return '0;
    if (r < 60) return base + IDX_W'(k);
    return IDX_W'($urandom);
  endfunction

  // output side: check each transaction, then pick the next stall
  always @(posedge clk_i) begin
    logic [IDX_W:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_indices.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got index %h end %b",
                 $time, out_index_o, primitive_end_o);
        errors++;
      end else begin
        want = pending_indices.pop_front();
        indices_checked++;
        if (out_index_o !== want[IDX_W-1:0]) begin
          $display("%0t: out_index mismatch, expected %h, got %h",
                   $time, want[IDX_W-1:0], out_index_o);
          errors++;
        end
        if (primitive_end_o !== want[IDX_W]) begin
          $display("%0t: primitive_end mismatch, expected %b, got %b",
                   $time, want[IDX_W], primitive_end_o);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d indices still expected", pending_indices.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    vector_row_t row;
    logic [2:0] topo;
    logic [IDX_W-1:0] base;
    logic last;
    int unsigned sent;
    int unsigned strip_len;

    topo_q = TOPO_RESET;
    older_q = '0;
    newer_q = '0;
    anchor_q = '0;
    seen_q = 0;
    odd_q = 1'b0;
    errors = 0;
    vertices_sent = 0;
    indices_checked = 0;
    topo_writes = 0;
    tx_idle_pct = 33;
    rx_stall_pct = 56;

    // triangle strip after reset, the fourth vertex makes an odd triangle
    add_vertex(16'h0000, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'hFFFF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h1234, 1'b0, 1'b1, 2'd3, 16'h0000, 16'hFFFF, 16'h1234);
    add_vertex(16'h5678, 1'b1, 1'b1, 2'd3, 16'hFFFF, 16'h5678, 16'h1234);
    add_topo(TOPO_POINTS);
    add_vertex(16'hFFFF, 1'b0, 1'b1, 2'd1, 16'hFFFF, 16'h0000, 16'h0000);
    add_vertex(16'h0000, 1'b1, 1'b1, 2'd1, 16'h0000, 16'h0000, 16'h0000);
    // line list, the odd vertex at the end of the list is dropped
    add_topo(TOPO_LINES);
    add_vertex(16'hAAAA, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h5555, 1'b0, 1'b1, 2'd2, 16'hAAAA, 16'h5555, 16'h0000);
    add_vertex(16'h0001, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    // line strip left open, then the topology write restarts assembly
    add_topo(TOPO_LINE_STRIP);
    add_vertex(16'h0010, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h0020, 1'b0, 1'b1, 2'd2, 16'h0010, 16'h0020, 16'h0000);
    add_vertex(16'h0030, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_topo(TOPO_TRIS);
    add_vertex(16'h0001, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h0002, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h0003, 1'b0, 1'b1, 2'd3, 16'h0001, 16'h0002, 16'h0003);
    add_vertex(16'h0004, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h0005, 1'b1, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_topo(TOPO_TRI_FAN);
    add_vertex(16'h0007, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h0008, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h0009, 1'b0, 1'b1, 2'd3, 16'h0007, 16'h0008, 16'h0009);
    add_vertex(16'h000A, 1'b1, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    // codes without meaning consume vertices silently
    add_topo(TOPO_UNDEF6);
    add_vertex(16'hFFFF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_vertex(16'h0001, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    add_topo(TOPO_UNDEF7);
    add_vertex(16'h0002, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    // strip too short for a triangle
    add_topo(TOPO_TRI_STRIP);
    add_vertex(16'h8000, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) write_topology(row.topo);
      else send_vertex(row.vtx, row.last, row.typed, row.n, row.idx);
    end

    // random strips, phases differ in topology and idling
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 4)
        0: begin
          tx_idle_pct = 33;
          rx_stall_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_stall_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      topo = (phase < 6) ? 3'(phase) : 3'($urandom_range(0, 5));
      write_topology(topo);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        strip_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                : $urandom_range(1, 7);
        base = IDX_W'($urandom);
        for (int k = 0; k < strip_len && sent < PHASE_ITEMS; k++) begin
          last = (k == strip_len - 1);
          // occasional broken strip flag
          if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
          send_vertex(pick_index(base, k), last, 1'b0, 2'd0, '0);
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_indices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);

    $display("sent %0d vertices over %0d topology writes, all six topologies and both unused codes",
             vertices_sent, topo_writes);
    $display("checked %0d output indices, %0d mismatches", indices_checked, errors);
    if (errors == 0 && pending_indices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/ptl_pkg.sv
sv/ptl_front.sv
sv/ptl_queue.sv
sv/ptl_back.sv
sv/primitive_topology_to_list.sv
sim/testbench.sv
